/* sv/assert_macros.svh */
// Assertion helpers shared by the shader RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lmls_pkg.sv */
package lmls_pkg;

  localparam int MaxLightsDef = 4;
  localparam int CoordBitsDef = 16;
  localparam int NumLightRegs = 4;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 48;

  localparam logic [CfgIdxW-1:0] RegLight0     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegLightCount = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDiffuse    = 3'd5;

  localparam logic [23:0] DiffuseReset = 24'hA0A0A4;

  // q search: 17 bits, high to low
  localparam int QBits   = 17;
  localparam int QCntW   = 5;
  localparam int DotW    = 35;  // signed dot product
  localparam int Len2W   = 36;  // sum of three squares of 17-bit diffs
  localparam int DotSqW  = 72;  // 16 * dot^2

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SEARCH,
    ST_OUT
  } cell_state_e;

  // cell to cell hand-off
  typedef struct packed {
    logic [16:0] best;
  } cell_link_t;

  function automatic logic signed [16:0] sext_coord(input logic [15:0] v, input int cw);
    logic signed [16:0] r;
    logic [15:0] m;
    m = 16'hFFFF >> (16 - cw);
    r = {1'b0, v & m};
    if (v[cw-1]) r = r - (17'sd1 <<< cw);
    return r;
  endfunction

endpackage

/* sv/lmls_cell.sv */
// One light: setup of dot and |d|^2, then a shift-add search for q, one bit per cycle.
module lmls_cell
  import lmls_pkg::*;
#(
  parameter int CoordBits = CoordBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              active_i,
  input  logic [47:0]       light_i,
  input  logic [15:0]       hit_i [3],
  input  logic [15:0]       nrm_i [3],
  input  cell_link_t        link_i,
  output cell_link_t        link_o,
  output logic              done_o
);

  localparam int Cw = (CoordBits < 16) ? CoordBits : 16;

  cell_state_e state_q, state_d;
  logic signed [DotW-1:0] dot_q, dot_d;
  logic [Len2W-1:0]  len2_q, len2_d;
  logic [DotSqW-1:0] dsq_q;
  logic [QBits-1:0]  q_q, q_d;
  logic [QCntW-1:0]  bit_q, bit_d;
  logic              act_q;
  // running q*q*len2 and q*len2, so each step needs only shifts and adds
  logic [DotSqW-1:0] q2len_q, q2len_d;
  logic [51:0]       qlen_q, qlen_d;

  logic signed [16:0] dl [3];
  logic signed [33:0] pr [3];
  logic [33:0]        sq [3];
  logic [QBits-1:0]   cand;
  logic [DotSqW-1:0]  trial;
  logic [65:0]        dsq_raw;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dl[k] = sext_coord(light_i[16*k +: 16], Cw) - sext_coord(hit_i[k], Cw);
      pr[k] = 34'(dl[k]) * 34'($signed(nrm_i[k]));
      sq[k] = 34'(dl[k] * dl[k]);
    end
  end

  // cand^2*len2 = q^2*len2 + 2^(b+1)*q*len2 + 2^(2b)*len2
  always_comb begin
    cand  = q_q | (QBits'(1) << bit_q);
    trial = q2len_q + (DotSqW'(qlen_q) << (bit_q + 5'd1))
          + (DotSqW'(len2_q) << {bit_q, 1'b0});
  end

  // dot is only squared when positive; it fits 33 bits
  assign dsq_raw = 66'(dot_q[32:0]) * 66'(dot_q[32:0]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_SETUP;
      ST_SETUP:  state_d = ST_SEARCH;
      ST_SEARCH: if (bit_q == '0) state_d = ST_OUT;
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    dot_d   = dot_q;
    len2_d  = len2_q;
    q_d     = q_q;
    bit_d   = bit_q;
    q2len_d = q2len_q;
    qlen_d  = qlen_q;
    case (state_q)
      ST_IDLE: begin
        dot_d  = DotW'(pr[0]) + DotW'(pr[1]) + DotW'(pr[2]);
        len2_d = Len2W'(sq[0]) + Len2W'(sq[1]) + Len2W'(sq[2]);
      end
      ST_SETUP: begin
        q_d     = '0;
        bit_d   = QCntW'(QBits - 1);
        q2len_d = '0;
        qlen_d  = '0;
      end
      ST_SEARCH: begin
        if (cand <= QBits'(65536) && trial <= dsq_q) begin
          q_d     = cand;
          q2len_d = trial;
          qlen_d  = qlen_q + (52'(len2_q) << bit_q);
        end
        if (bit_q != '0) bit_d = bit_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dot_q   <= dot_d;
    len2_q  <= len2_d;
    q_q     <= q_d;
    bit_q   <= bit_d;
    q2len_q <= q2len_d;
    qlen_q  <= qlen_d;
    if (state_q == ST_IDLE) act_q <= active_i;
    if (state_q == ST_SETUP)
      dsq_q <= (dot_q > 0) ? DotSqW'({dsq_raw, 4'b0000}) : '0;
  end

  logic [16:0] mine;
  assign mine = (act_q && len2_q != '0 && dot_q > 0) ?
                ((q_q > 17'd65535) ? 17'd65535 : q_q) : 17'd0;
  assign link_o.best = (mine > link_i.best) ? mine : link_i.best;
  assign done_o = (state_q == ST_OUT);

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_setup_to_search, state_q == ST_SETUP, state_q == ST_SEARCH, "cell skipped search")
  `ASSERT_CLK(a_best_cap, link_o.best <= 17'd65535, "lightness above cap")

endmodule

/* sv/lambert_max_light_shader_top.sv */
// Lambert shading with the brightest of up to MaxLights point lights.
// Input channel s_axis: one hit point and unit normal per beat.
// Output channel m_axis: lightness and scaled diffuse color, one per hit.
// Config port: cfg_we_i / cfg_idx_i / cfg_data_i, lights 0..3, count, color.
// Each light has a cell; all cells run in parallel, and their results are
// chained cell to cell to form the running maximum.
// Steps: dot and |d|^2 registered, setup (16*dot^2), 17 search steps,
// then the max into best_q and the color into the result register.
// One hit in flight at a time; with the receiver ready, how often a new hit
// is taken is set by the 17-step bit search for the cosine in each cell.
// Reset clears the control state; registers return to zero lights and
// gray color. A stalled receiver holds the result register; the next hit
// is taken once that result has left.
module lambert_max_light_shader_top
  import lmls_pkg::*;
#(
  parameter int MaxLights = MaxLightsDef,
  parameter int CoordBits = CoordBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // hit_x, hit_y, hit_z, normal_x, normal_y, normal_z
  input  logic [95:0]         s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // lightness, red, green, blue
  output logic [39:0]         m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int NCell = (MaxLights < NumLightRegs) ? MaxLights : NumLightRegs;

  logic [47:0] light_q [NumLightRegs];
  logic [2:0]  count_q;
  logic [23:0] rgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLightRegs; i++) light_q[i] <= '0;
      count_q <= '0;
      rgb_q   <= DiffuseReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i < RegLightCount) light_q[cfg_idx_i[1:0]] <= cfg_data_i;
      else if (cfg_idx_i == RegLightCount) count_q <= cfg_data_i[2:0];
      else if (cfg_idx_i == RegDiffuse) rgb_q <= cfg_data_i[23:0];
    end
  end

  logic        busy_q, start_q, color_q;
  logic [15:0] hit_q [3];
  logic [15:0] nrm_q [3];
  logic        take;
  logic        done;
  logic [16:0] best_q;
  logic        ovalid_q;
  logic [39:0] odata_q;

  assign s_axis_tready = !busy_q && !ovalid_q;
  assign take = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int k = 0; k < 3; k++) begin
        hit_q[k] <= s_axis_tdata[16*k +: 16];
        nrm_q[k] <= s_axis_tdata[48+16*k +: 16];
      end
    end
  end

  cell_link_t link [NCell+1];
  logic [NCell-1:0] done_v;
  assign link[0].best = '0;

  for (genvar g = 0; g < NCell; g++) begin : g_cell
    lmls_cell #(.CoordBits(CoordBits)) u_cell (
      .clk_i, .rst_ni,
      .start_i (start_q),
      .active_i(3'(g) < count_q),
      .light_i (light_q[g]),
      .hit_i   (hit_q),
      .nrm_i   (nrm_q),
      .link_i  (link[g]),
      .link_o  (link[g+1]),
      .done_o  (done_v[g])
    );
  end
  // all cells step in lockstep
  assign done = &done_v;

  logic [24:0] pr, pg, pb;
  always_comb begin
    pr = 25'(rgb_q[23:16]) * 25'(best_q[15:0]) + 25'd32768;
    pg = 25'(rgb_q[15:8])  * 25'(best_q[15:0]) + 25'd32768;
    pb = 25'(rgb_q[7:0])   * 25'(best_q[15:0]) + 25'd32768;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; start_q <= 1'b0; color_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      start_q <= take;
      color_q <= done;
      if (take) busy_q <= 1'b1;
      if (color_q) begin
        busy_q <= 1'b0; ovalid_q <= 1'b1;
      end else if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) best_q <= link[NCell].best;
    if (color_q) odata_q <= {pb[23:16], pg[23:16], pr[23:16], best_q[15:0]};
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  `include "assert_macros.svh"
  `ASSERT_CLK(a_no_take_busy, !(take && busy_q), "hit taken while busy")
  `ASSERT_NEXT(a_color_valid, color_q, m_axis_tvalid, "result lost")
  `ASSERT_CLK(a_done_busy, !done || busy_q, "done without hit")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

// Shader testbench: drives hit/normal beats into s_axis, writes the light,
// count and color registers between phases, and checks every m_axis beat
// against an integer model of the max-over-lights Lambert cosine and color.

class shade_board;
  logic [47:0] light_pos [4];
  logic [2:0]  light_cnt;
  logic [23:0] diffuse;
  logic [39:0] pending_q [$];
  int          errors;

  function new();
    foreach (light_pos[i]) light_pos[i] = '0;
    light_cnt = '0;
    diffuse   = 24'hA0A0A4;
    errors    = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [47:0] val);
    if (idx < lmls_pkg::RegLightCount) light_pos[idx] = val;
    else if (idx == lmls_pkg::RegLightCount) light_cnt = val[2:0];
    else if (idx == lmls_pkg::RegDiffuse) diffuse = val[23:0];
  endfunction

  // floor(65536*cos) by bit search: q*q*len2 <= 16*dot^2
  function logic [16:0] cosine_q(longint dot, longint unsigned len2);
    logic [16:0]  q;
    logic [16:0]  cand;
    logic [127:0] rhs;
    logic [127:0] lhs;
    q = '0;
    if (dot <= 0 || len2 == 0) return '0;
    rhs = 128'(dot) * 128'(dot) * 16;
    for (int b = 16; b >= 0; b--) begin
      cand = q | (17'd1 << b);
      if (cand > 17'd65536) continue;
      lhs = 128'(cand) * 128'(cand) * 128'(len2);
      if (lhs <= rhs) q = cand;
    end
    return q;
  endfunction

  function void note_hit(logic [95:0] hit);
    longint      p [3];
    longint      n [3];
    longint      dot;
    longint      d;
    longint unsigned len2;
    logic [16:0] c;
    logic [16:0] best;
    int          cnt;
    logic [15:0] lt;
    logic [7:0]  r, g, bl;
    best = '0;
    for (int k = 0; k < 3; k++) begin
      p[k] = longint'($signed(hit[16*k +: 16]));
      n[k] = longint'($signed(hit[48 + 16*k +: 16]));
    end
    cnt = (light_cnt > 4) ? 4 : light_cnt;
    for (int i = 0; i < cnt; i++) begin
      dot  = 0;
      len2 = 0;
      for (int k = 0; k < 3; k++) begin
        d = longint'($signed(light_pos[i][16*k +: 16])) - p[k];
        dot += n[k] * d;
        len2 += longint'(d * d);
      end
      c = cosine_q(dot, len2);
      if (c > best) best = c;
    end
    if (best > 65535) best = 65535;
    lt = best[15:0];
    r  = 8'(((32'(diffuse[23:16]) * lt) + 32768) >> 16);
    g  = 8'(((32'(diffuse[15:8]) * lt) + 32768) >> 16);
    bl = 8'(((32'(diffuse[7:0]) * lt) + 32768) >> 16);
    pending_q.push_back({bl, g, r, lt});
  endfunction

  function void check_result(logic [39:0] got);
    logic [39:0] exp;
    if (pending_q.size() == 0) begin
      $error("unexpected result beat %h", got);
      errors++;
      return;
    end
    exp = pending_q.pop_front();
    if (got[15:0] !== exp[15:0]) begin
      $error("lightness exp %0d got %0d", exp[15:0], got[15:0]); errors++;
    end
    if (got[23:16] !== exp[23:16]) begin
      $error("red exp %0d got %0d", exp[23:16], got[23:16]); errors++;
    end
    if (got[31:24] !== exp[31:24]) begin
      $error("green exp %0d got %0d", exp[31:24], got[31:24]); errors++;
    end
    if (got[39:32] !== exp[39:32]) begin
      $error("blue exp %0d got %0d", exp[39:32], got[39:32]); errors++;
    end
  endfunction
endclass

module tb;
  import lmls_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // hit_x, hit_y, hit_z, normal_x, normal_y, normal_z
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // lightness, red, green, blue
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  shade_board board;
  longint cycles = 0;
  bit  hold_sink = 1'b0;           // long receiver hold-off requested
  bit  sent_done = 1'b0;

  lambert_max_light_shader_top dut (.*);

  initial forever #6 clk_i = ~clk_i;

  // timeout guard, sized for the 700 random hits and the random stalls on both sides
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  // wait for the block to drain before touching registers
  task automatic drain();
    while (board.pending_q.size() != 0) @(posedge clk_i);
    wait_cycles(30);
  endtask

  task automatic send_hit(logic [95:0] hit, bit gaps);
    if (gaps) wait_cycles($urandom_range(0, 18));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= hit;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_hit(hit);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rnd_normal();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [95:0] rnd_hit(bit near);
    logic [95:0] h;
    h = {$urandom, $urandom, $urandom};
    for (int k = 3; k < 6; k++) h[16*k +: 16] = rnd_normal();
    // keep most points near the lights so cosines spread widely
    if (near) for (int k = 0; k < 3; k++) h[16*k +: 16] = 16'($signed(h[16*k +: 12]));
    return h;
  endfunction

  function automatic logic [47:0] rnd_light();
    logic [47:0] l;
    l = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0)
      for (int k = 0; k < 3; k++) l[16*k +: 16] = 16'($signed(l[16*k +: 12]));
    return l;
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        wait_cycles(300);
        hold_sink = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        wait_cycles($urandom_range(1, 18));
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end
  end

  initial begin
    logic [95:0] h;
    board = new();
    wait_cycles(2);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state: no lights, so all zero
    send_hit('0, 0);
    drain();

    // one light straight above the origin
    write_reg(RegLight0, {16'sd256, 16'sd0, 16'sd0});
    write_reg(RegLightCount, 3'd1);
    send_hit({16'sd16384, 16'sd0, 16'sd0, 48'd0}, 0);        // cosine one
    send_hit({-16'sd16384, 16'sd0, 16'sd0, 48'd0}, 0);       // facing away
    send_hit({16'sd16384, 16'sd0, 16'sd0, 16'sd256, 32'd0}, 0); // on the light
    send_hit({16'sd16384, 16'sd16384, 16'sd0, 48'd0}, 0);    // saturates
    send_hit({16'sd0, 16'sd16384, 16'sd0, 48'd0}, 0);        // perpendicular
    send_hit({16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 0);
    send_hit({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000}, 0);
    send_hit({16'sd16384, 16'sd0, 16'sd0, 16'sd255, 16'sd1, 16'sd1}, 0);
    drain();

    // extreme lights, all four, count beyond four, odd colors
    write_reg(RegLight0 + 3'd1, 48'h8000_8000_8000);
    write_reg(RegLight0 + 3'd2, 48'h7FFF_7FFF_7FFF);
    write_reg(RegLight0 + 3'd3, {16'sd0, 16'sd256, 16'sd0});
    write_reg(RegLightCount, 3'd7);
    write_reg(RegDiffuse, 24'hFFFFFF);
    write_reg(RegDiffuse + 3'd1, 48'hFFFF_FFFF_FFFF);   // no such register
    for (int i = 0; i < 6; i++) send_hit(rnd_hit(i[0]), 0);
    drain();
    write_reg(RegDiffuse, 24'h000000);
    send_hit({16'sd16384, 80'd0}, 0);
    drain();

    // random phases; one hold-off while the sender keeps pushing
    for (int ph = 0; ph < 14; ph++) begin
      for (int r = 0; r < 4; r++) write_reg(RegLight0 + 3'(r), rnd_light());
      write_reg(RegLightCount, 3'($urandom_range(0, 7)));
      write_reg(RegDiffuse, 24'($urandom));
      if (ph == 3) hold_sink = 1'b1;
      for (int i = 0; i < 50; i++) begin
        h = rnd_hit($urandom_range(0, 4) != 0);
        send_hit(h, 1'b1);
      end
      drain();
    end

    while (board.pending_q.size() != 0) @(posedge clk_i);
    wait_cycles(40);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
